@@ sv/wcts_pkg.sv @@
package wcts_pkg;

  localparam int unsigned NumCodes = 27;
  localparam int unsigned CodeW    = 5;
  localparam int unsigned LedW     = 7;

  localparam logic [CodeW-1:0] CODE_IT      = 5'd0;
  localparam logic [CodeW-1:0] CODE_IS      = 5'd1;
  localparam logic [CodeW-1:0] CODE_DOT1    = 5'd2;
  localparam logic [CodeW-1:0] CODE_DOT2    = 5'd3;
  localparam logic [CodeW-1:0] CODE_DOT3    = 5'd4;
  localparam logic [CodeW-1:0] CODE_DOT4    = 5'd5;
  localparam logic [CodeW-1:0] CODE_FIVE    = 5'd6;
  localparam logic [CodeW-1:0] CODE_TEN     = 5'd7;
  localparam logic [CodeW-1:0] CODE_TWENTY  = 5'd8;
  localparam logic [CodeW-1:0] CODE_QUARTER = 5'd9;
  localparam logic [CodeW-1:0] CODE_HALF    = 5'd10;
  localparam logic [CodeW-1:0] CODE_TO      = 5'd11;
  localparam logic [CodeW-1:0] CODE_PAST    = 5'd12;
  localparam logic [CodeW-1:0] CODE_HOUR0   = 5'd13;
  localparam logic [CodeW-1:0] CODE_CLOCK   = 5'd26;

  typedef logic [NumCodes-1:0] code_mask_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

  typedef struct packed {
    logic [LedW-1:0] first;
    logic [LedW-1:0] last;
  } led_span_t;

  // LED span of every word on the grid
  function automatic led_span_t seg_rom(input logic [CodeW-1:0] code);
    led_span_t s;
    case (code)
      5'd0:    s = '{7'd102, 7'd103};
      5'd1:    s = '{7'd105, 7'd107};
      5'd2:    s = '{7'd101, 7'd101};
      5'd3:    s = '{7'd113, 7'd113};
      5'd4:    s = '{7'd0,   7'd0};
      5'd5:    s = '{7'd12,  7'd12};
      5'd6:    s = '{7'd109, 7'd112};
      5'd7:    s = '{7'd97,  7'd100};
      5'd8:    s = '{7'd90,  7'd96};
      5'd9:    s = '{7'd83,  7'd89};
      5'd10:   s = '{7'd57,  7'd60};
      5'd11:   s = '{7'd76,  7'd78};
      5'd12:   s = '{7'd68,  7'd71};
      5'd13:   s = '{7'd53,  7'd56};
      5'd14:   s = '{7'd54,  7'd56};
      5'd15:   s = '{7'd46,  7'd49};
      5'd16:   s = '{7'd35,  7'd38};
      5'd17:   s = '{7'd42,  7'd45};
      5'd18:   s = '{7'd64,  7'd67};
      5'd19:   s = '{7'd30,  7'd34};
      5'd20:   s = '{7'd13,  7'd18};
      5'd21:   s = '{7'd24,  7'd27};
      5'd22:   s = '{7'd5,   7'd8};
      5'd23:   s = '{7'd8,   7'd11};
      5'd24:   s = '{7'd62,  7'd64};
      5'd25:   s = '{7'd19,  7'd23};
      5'd26:   s = '{7'd1,   7'd3};
      default: s = '{7'd102, 7'd103};
    endcase
    return s;
  endfunction

endpackage

@@ sv/wcts_ctrl.sv @@
module wcts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output wcts_pkg::dp_cmd_t   cmd,
  input  wcts_pkg::dp_status_t status
);

  wcts_pkg::state_t state_r;
  wcts_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wcts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    case (state_r)
      wcts_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = wcts_pkg::ST_EMIT;
        end
      end
      wcts_pkg::ST_EMIT: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        if (status.last) begin
          state_nxt = wcts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wcts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/wcts_datapath.sv @@
module wcts_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wcts_pkg::dp_cmd_t             cmd,
  output wcts_pkg::dp_status_t          status,
  input  logic [4:0]                    hour,
  input  logic [5:0]                    minute,
  output logic                          out_valid,
  output logic [wcts_pkg::CodeW-1:0]    out_word_code,
  output logic [wcts_pkg::LedW-1:0]     out_first_led,
  output logic [wcts_pkg::LedW-1:0]     out_last_led,
  output logic                          out_final_segment
);

  // minute / 5 by reciprocal: floor(m * 205 / 1024) is exact for m below 64
  logic [13:0] prod;
  logic [3:0]  q;
  logic [5:0]  q_times5;
  logic [2:0]  dots;
  logic [4:0]  h12;
  logic [3:0]  h;
  logic [3:0]  h_adv;
  logic [wcts_pkg::CodeW-1:0] hour_code;
  wcts_pkg::code_mask_t mask_load;

  always_comb begin
    prod     = 14'({8'd0, minute} * 14'd205);
    q        = prod[13:10];
    q_times5 = 6'({2'd0, q} * 6'd5);
    dots     = 3'(minute - q_times5);

    if (hour >= 5'd24) begin
      h12 = hour - 5'd24;
    end else if (hour >= 5'd12) begin
      h12 = hour - 5'd12;
    end else begin
      h12 = hour;
    end
    h = (h12 == 5'd0) ? 4'd12 : h12[3:0];
    if (minute >= 6'd25) begin
      h_adv = (h == 4'd12) ? 4'd1 : h + 4'd1;
    end else begin
      h_adv = h;
    end
    if (h_adv == 4'd1 && minute > 6'd4) begin
      hour_code = wcts_pkg::CODE_HOUR0;
    end else begin
      hour_code = wcts_pkg::CODE_HOUR0 + {1'b0, h_adv};
    end

    mask_load = '0;
    mask_load[wcts_pkg::CODE_IT]      = 1'b1;
    mask_load[wcts_pkg::CODE_IS]      = 1'b1;
    mask_load[wcts_pkg::CODE_DOT1]    = (dots > 3'd0);
    mask_load[wcts_pkg::CODE_DOT2]    = (dots > 3'd1);
    mask_load[wcts_pkg::CODE_DOT3]    = (dots > 3'd2);
    mask_load[wcts_pkg::CODE_DOT4]    = (dots > 3'd3);
    mask_load[wcts_pkg::CODE_FIVE]    = (q == 4'd1 || q == 4'd5 || q == 4'd7 || q == 4'd11);
    mask_load[wcts_pkg::CODE_TEN]     = (q == 4'd2 || q == 4'd10);
    mask_load[wcts_pkg::CODE_TWENTY]  = (q == 4'd4 || q == 4'd8);
    mask_load[wcts_pkg::CODE_QUARTER] = (q == 4'd3 || q == 4'd9);
    mask_load[wcts_pkg::CODE_HALF]    = (q == 4'd5 || q == 4'd6 || q == 4'd7);
    mask_load[wcts_pkg::CODE_TO]      = (q == 4'd5 || q == 4'd8 || q == 4'd9 ||
                                         q == 4'd10 || q == 4'd11);
    mask_load[wcts_pkg::CODE_PAST]    = (q == 4'd1 || q == 4'd2 || q == 4'd3 ||
                                         q == 4'd4 || q == 4'd7);
    mask_load[hour_code]              = 1'b1;
    mask_load[wcts_pkg::CODE_CLOCK]   = (minute < 6'd5);
  end

  // pending words; the emission order is ascending code, so always take the lowest
  wcts_pkg::code_mask_t mask_r;
  wcts_pkg::code_mask_t mask_nxt;
  wcts_pkg::code_mask_t mask_rest;
  logic [wcts_pkg::CodeW-1:0] low_code;
  wcts_pkg::led_span_t        span;

  always_comb begin
    low_code = wcts_pkg::CODE_IT;
    for (int i = wcts_pkg::NumCodes - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_code = wcts_pkg::CodeW'(i);
      end
    end
    mask_rest = mask_r & (mask_r - wcts_pkg::code_mask_t'(1));
    span      = wcts_pkg::seg_rom(low_code);
    status.last = (mask_rest == '0);

    mask_nxt = mask_r;
    if (cmd.load) begin
      mask_nxt = mask_load;
    end else if (cmd.step) begin
      mask_nxt = mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
  end

  logic                       valid_r;
  logic [wcts_pkg::CodeW-1:0] code_r;
  logic [wcts_pkg::LedW-1:0]  first_r;
  logic [wcts_pkg::LedW-1:0]  last_r;
  logic                       final_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      code_r  <= low_code;
      first_r <= span.first;
      last_r  <= span.last;
      final_r <= status.last;
    end
  end

  assign out_valid         = valid_r;
  assign out_word_code     = code_r;
  assign out_first_led     = first_r;
  assign out_last_led      = last_r;
  assign out_final_segment = final_r;

endmodule

@@ sv/word_clock_time_to_segments.sv @@
// Word clock segment generator.
// Input: pulse start with in_hour (0..23) and in_minute (0..59); the request is
// taken at a rising edge with start high and busy low. busy stays high while the
// words for that time are being sent.
// Output: each lit word comes as one result on out_word_code, out_first_led and
// out_last_led, valid for exactly one cycle while out_valid is high; the last
// word of a time has out_final_segment set. Words arrive in ascending code order.
// Sequence: the accepting edge loads the pending-word register and enters the
// emit state, where its lowest-bit pick sends one word per cycle to the output
// registers. A time has n words (4..10); busy stays high until the last word
// is picked, so the final word is shown after busy has dropped.
// The receiver cannot stall: results must be captured when out_valid is high.
// A new request may be taken in the cycle the final word is shown.
// Reset (rst_n low, synchronous) returns to idle and drops any words in flight.
module word_clock_time_to_segments (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [4:0]                    in_hour,
  input  logic [5:0]                    in_minute,
  output logic                          out_valid,
  output logic [wcts_pkg::CodeW-1:0]    out_word_code,
  output logic [wcts_pkg::LedW-1:0]     out_first_led,
  output logic [wcts_pkg::LedW-1:0]     out_last_led,
  output logic                          out_final_segment
);

  wcts_pkg::dp_cmd_t    cmd;
  wcts_pkg::dp_status_t status;

  wcts_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  wcts_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .hour              (in_hour),
    .minute            (in_minute),
    .out_valid         (out_valid),
    .out_word_code     (out_word_code),
    .out_first_led     (out_first_led),
    .out_last_led      (out_last_led),
    .out_final_segment (out_final_segment)
  );

  a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_segment |-> !busy)
    else $error("final word shown while still busy");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_segment |-> busy)
    else $error("non-final word shown with nothing pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted request did not start emission");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word_code <= wcts_pkg::CODE_CLOCK)
    else $error("word code out of range");

endmodule
